// File: sv/rhwp_pkg.sv
package rhwp_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic        start_of_message;
		logic        end_of_message;
	} word_item_t;

	typedef struct packed {
		logic        header_status;
		logic [31:0] xid;
		logic        msg_type;
		logic [31:0] program_res;
		logic [31:0] program_version;
		logic [31:0] procedure;
		logic        reply_status;
		logic [2:0]  accept_status;
		logic        reject_status;
		logic [31:0] low_version;
		logic [31:0] high_version;
		logic [31:0] auth_error;
	} header_result_t;

	// parse branch, one-hot
	typedef enum logic [7:0] {
		BR_COMMON = 8'b0000_0001,
		BR_CALL   = 8'b0000_0010,
		BR_REPLY  = 8'b0000_0100,
		BR_ACC    = 8'b0000_1000,
		BR_PROGMM = 8'b0001_0000,
		BR_DENIED = 8'b0010_0000,
		BR_RPCMM  = 8'b0100_0000,
		BR_AUTH   = 8'b1000_0000
	} branch_t;

	typedef enum logic [1:0] {
		GO_ON  = 2'd0,
		GO_OK  = 2'd1,
		GO_BAD = 2'd2
	} outcome_t;

	localparam int unsigned PosW = 4;
	localparam logic [PosW-1:0] POS_MAX = 4'd15;

	// word positions within the header
	localparam logic [PosW-1:0] POS_XID         = 4'd0;
	localparam logic [PosW-1:0] POS_TYPE        = 4'd1;
	localparam logic [PosW-1:0] POS_RPCVERS     = 4'd2;
	localparam logic [PosW-1:0] POS_PROG        = 4'd3;
	localparam logic [PosW-1:0] POS_VERS        = 4'd4;
	localparam logic [PosW-1:0] POS_PROC        = 4'd5;
	localparam logic [PosW-1:0] POS_CRED_FLAVOR = 4'd6;
	localparam logic [PosW-1:0] POS_CRED_LEN    = 4'd7;
	localparam logic [PosW-1:0] POS_VERF_FLAVOR = 4'd8;
	localparam logic [PosW-1:0] POS_VERF_LEN    = 4'd9;
	localparam logic [PosW-1:0] POS_RVERF_FLAVOR = 4'd3;
	localparam logic [PosW-1:0] POS_RVERF_LEN    = 4'd4;
	localparam logic [PosW-1:0] POS_RPCMM_LOW    = 4'd4;
	localparam logic [PosW-1:0] POS_PROGMM_LOW   = 4'd6;

	localparam logic [31:0] MSG_CALL          = 32'd0;
	localparam logic [31:0] MSG_REPLY         = 32'd1;
	localparam logic [31:0] RPC_VERSION       = 32'd2;
	localparam logic [31:0] AUTH_NONE         = 32'd0;
	localparam logic [31:0] REPLY_ACCEPTED    = 32'd0;
	localparam logic [31:0] REPLY_DENIED      = 32'd1;
	localparam logic [31:0] ACC_PROG_MISMATCH = 32'd2;
	localparam logic [31:0] ACC_SYSTEM_ERR    = 32'd5;
	localparam logic [31:0] REJ_RPC_MISMATCH  = 32'd0;
	localparam logic [31:0] REJ_AUTH_ERROR    = 32'd1;

endpackage

// File: sv/rhwp_stream_if.sv
interface rhwp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/rpc_header_word_parser.sv
// RPC header word parser.
// words: one 32-bit XDR word per request, with start and end-of-message flags.
//   A start flag restarts the parse; an unfinished message is dropped silently.
// results: one request per message header, either the decoded fields or
//   header_status = 1 (malformed or truncated) with every other field zero.
//   Words after the result, or before any start, produce nothing.
// Pipeline: a word accepted on words passes through the input register, the parse
//   logic and the output register before its result shows on results.
// Throughput: one word per cycle while results are taken; the parse state updates once per word.
// Reset: nothing in flight, parser skips until a start-of-message word.
// Stall: a result waits in the output register while results.ready is low;
//   one more word may sit in the input register, after which words.ready
//   drops until the result is taken.
module rpc_header_word_parser (
	input logic          clk,
	input logic          arst_n,
	rhwp_stream_if.sink   words,
	rhwp_stream_if.source results
);
	import rhwp_pkg::*;

	logic           s1_valid_q;
	word_item_t     s1_item_q;
	logic           out_valid_q;
	header_result_t out_data_q;
	logic           adv;
	logic           emit;
	header_result_t result;

	// stage 1 moves on when the output register is free or being drained
	assign adv         = !out_valid_q || results.ready;
	assign words.ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (words.ready) begin
			s1_valid_q <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) s1_item_q <= words.data;
	end

	rhwp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_valid_q && adv),
		.item   (s1_item_q),
		.emit   (emit),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) out_data_q <= result;
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

`ifndef SYNTH
	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !adv) |-> !words.ready)
		else $error("word taken while stage 1 is blocked");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> words.ready)
		else $error("empty input register refused a word");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("pending result lost or changed while stalled");
`endif

endmodule

// File: sv/rhwp_parser.sv
module rhwp_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  rhwp_pkg::word_item_t    item,
	output logic                    emit,
	output rhwp_pkg::header_result_t result
);
	import rhwp_pkg::*;

	logic [PosW-1:0] pos_q, base_pos, n_pos;
	branch_t         branch_q, base_br, n_br;
	logic            skip_q;
	logic            type_q, denied_q, reject_q, pend_q;
	logic [2:0]      acc_q;
	logic            base_type, base_denied, base_reject, base_pend;
	logic [2:0]      base_acc;
	logic            n_type, n_denied, n_reject, n_pend;
	logic [2:0]      n_acc;
	logic [31:0]     xid_q, prog_q, vers_q, proc_q, low_q, high_q;
	logic [31:0]     n_xid, n_prog, n_vers, n_proc, n_low, n_high;
	logic [31:0]     w;
	logic            act;
	outcome_t        outcome;

	assign w   = item.data_word;
	assign act = step && (item.start_of_message || !skip_q);

	always_comb begin
		// a start word parses from a clean slate
		base_pos    = item.start_of_message ? '0 : pos_q;
		base_br     = item.start_of_message ? BR_COMMON : branch_q;
		base_type   = item.start_of_message ? 1'b0 : type_q;
		base_denied = item.start_of_message ? 1'b0 : denied_q;
		base_reject = item.start_of_message ? 1'b0 : reject_q;
		base_pend   = item.start_of_message ? 1'b0 : pend_q;
		base_acc    = item.start_of_message ? 3'd0 : acc_q;

		n_br     = base_br;
		n_type   = base_type;
		n_denied = base_denied;
		n_reject = base_reject;
		n_pend   = base_pend;
		n_acc    = base_acc;
		n_xid    = xid_q;
		n_prog   = prog_q;
		n_vers   = vers_q;
		n_proc   = proc_q;
		n_low    = low_q;
		n_high   = high_q;
		outcome  = GO_ON;

		if (base_pos == POS_XID) begin
			n_xid = w;
		end else if (base_pos == POS_TYPE) begin
			if (w == MSG_CALL) begin
				n_br = BR_CALL;
			end else if (w == MSG_REPLY) begin
				n_br   = BR_REPLY;
				n_type = 1'b1;
			end else begin
				outcome = GO_BAD;
			end
		end else begin
			case (base_br)
				BR_CALL: begin
					case (base_pos)
						POS_RPCVERS: begin
							// wrong version is reported once the procedure word is in
							if (w != RPC_VERSION) n_pend = 1'b1;
						end
						POS_PROG: n_prog = w;
						POS_VERS: n_vers = w;
						POS_PROC: begin
							n_proc = w;
							if (base_pend) outcome = GO_BAD;
						end
						POS_CRED_FLAVOR, POS_VERF_FLAVOR: begin
							if (w != AUTH_NONE) n_pend = 1'b1;
						end
						POS_CRED_LEN: begin
							if (base_pend || w != 32'd0) outcome = GO_BAD;
						end
						POS_VERF_LEN: begin
							outcome = (base_pend || w != 32'd0) ? GO_BAD : GO_OK;
						end
						default: outcome = GO_BAD;
					endcase
				end
				BR_REPLY: begin
					if (w == REPLY_ACCEPTED) begin
						n_br = BR_ACC;
					end else if (w == REPLY_DENIED) begin
						n_br     = BR_DENIED;
						n_denied = 1'b1;
					end else begin
						outcome = GO_BAD;
					end
				end
				BR_ACC: begin
					if (base_pos == POS_RVERF_FLAVOR) begin
						if (w != AUTH_NONE) n_pend = 1'b1;
					end else if (base_pos == POS_RVERF_LEN) begin
						if (base_pend || w != 32'd0) outcome = GO_BAD;
					end else if (w > ACC_SYSTEM_ERR) begin
						outcome = GO_BAD;
					end else begin
						n_acc = base_acc | w[2:0];
						if (w == ACC_PROG_MISMATCH) n_br = BR_PROGMM;
						else outcome = GO_OK;
					end
				end
				BR_PROGMM: begin
					if (base_pos == POS_PROGMM_LOW) begin
						n_low = w;
					end else begin
						n_high  = w;
						outcome = GO_OK;
					end
				end
				BR_DENIED: begin
					if (w == REJ_RPC_MISMATCH) begin
						n_br = BR_RPCMM;
					end else if (w == REJ_AUTH_ERROR) begin
						n_br     = BR_AUTH;
						n_reject = 1'b1;
					end else begin
						outcome = GO_BAD;
					end
				end
				BR_RPCMM: begin
					if (base_pos == POS_RPCMM_LOW) begin
						n_low = w;
					end else begin
						n_high  = w;
						outcome = GO_OK;
					end
				end
				BR_AUTH: begin
					n_low   = w;
					outcome = GO_OK;
				end
				default: outcome = GO_BAD;
			endcase
		end

		// message ran out before the header did
		if (outcome == GO_ON && item.end_of_message) outcome = GO_BAD;

		n_pos = (base_pos == POS_MAX) ? base_pos : base_pos + 4'd1;
	end

	assign emit = act && (outcome != GO_ON);

	always_comb begin
		result = '0;
		if (outcome == GO_BAD) begin
			result.header_status = 1'b1;
		end else begin
			result.xid      = n_xid;
			result.msg_type = n_type;
			if (n_br == BR_CALL) begin
				result.program_res     = n_prog;
				result.program_version = n_vers;
				result.procedure       = n_proc;
			end else begin
				result.reply_status = n_denied;
				if (n_br inside {BR_ACC, BR_PROGMM}) result.accept_status = n_acc;
				if (n_br inside {BR_AUTH, BR_RPCMM}) result.reject_status = n_reject;
				if (n_br inside {BR_PROGMM, BR_RPCMM}) begin
					result.low_version  = n_low;
					result.high_version = n_high;
				end
				// auth error word shares the low register
				if (n_br == BR_AUTH) result.auth_error = n_low;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			branch_q <= BR_COMMON;
			skip_q   <= 1'b1;
			type_q   <= 1'b0;
			denied_q <= 1'b0;
			reject_q <= 1'b0;
			pend_q   <= 1'b0;
			acc_q    <= 3'd0;
		end else if (act) begin
			pos_q    <= n_pos;
			branch_q <= n_br;
			skip_q   <= emit;
			type_q   <= n_type;
			denied_q <= n_denied;
			reject_q <= n_reject;
			pend_q   <= n_pend;
			acc_q    <= n_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			xid_q  <= n_xid;
			prog_q <= n_prog;
			vers_q <= n_vers;
			proc_q <= n_proc;
			low_q  <= n_low;
			high_q <= n_high;
		end
	end

`ifndef SYNTH
	a_emit_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> step)
		else $error("result produced without a word in hand");

	a_bad_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && result.header_status) |-> (result.xid == 32'd0 && !result.msg_type))
		else $error("malformed result carries header fields");

	a_skip_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> skip_q)
		else $error("parser did not return to skipping after a result");
`endif

endmodule
